// ----- hw/rtl/assert_macros.svh -----
// assertion helpers, clocked on clk, disabled during rst unless noted
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
// checked across reset
`define ASSERT_AFTER_RESET(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);
`endif

// ----- hw/rtl/ncdf_pkg.sv -----
`default_nettype none
package ncdf_pkg;

  localparam int WF = 30;
  localparam int DIV_STAGES = 31;
  localparam int EXP_TERMS = 12;
  localparam int EXP_LAT = 1 + 3 * EXP_TERMS + 5 + 1;
  localparam int POLY_LAT = 1 + DIV_STAGES + 5;
  localparam int SIDE_LAT = DIV_STAGES + EXP_LAT;
  localparam int ALIGN_LAT = EXP_LAT - POLY_LAT;

  localparam logic [1:0] REG_MEAN = 2'd0;
  localparam logic [1:0] REG_STD_DEV = 2'd1;

  localparam logic [30:0] ONE_Q = 31'h4000_0000;

  localparam logic [27:0] K_B0 = 28'd248723596;
  localparam logic signed [33:0] K_B1 = 34'sd342933307;
  localparam logic signed [33:0] K_B2 = -34'sd382857446;
  localparam logic signed [33:0] K_B3 = 34'sd1912847369;
  localparam logic signed [33:0] K_B4 = -34'sd1955558716;
  localparam logic signed [33:0] K_B5 = 34'sd1428371292;
  localparam logic [28:0] K_INV_SQRT_2PI = 29'd428361012;

  localparam logic [28:0] K_EXPNEG [5] = '{
    29'd395007542, 29'd145315154, 29'd19666268, 29'd360201, 29'd121
  };

  // horner addends, last step has none
  localparam logic signed [33:0] HORNER_ADD [5] = '{K_B4, K_B3, K_B2, K_B1, 34'sd0};

  // term j divides by 12 - j
  localparam logic [3:0] EXP_DIV [EXP_TERMS] = '{
    4'd12, 4'd11, 4'd10, 4'd9, 4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1
  };
  // floor(2^32 / k)
  localparam logic [32:0] EXP_RECIP [EXP_TERMS] = '{
    33'd357913941, 33'd390451572, 33'd429496729, 33'd477218588,
    33'd536870912, 33'd613566756, 33'd715827882, 33'd858993459,
    33'd1073741824, 33'd1431655765, 33'd2147483648, 33'd4294967296
  };

  typedef struct packed {
    logic [4:0]  n;
    logic [29:0] r;
  } ncdf_yr_t;

  typedef struct packed {
    logic v;
    logic neg;
    logic far;
  } ncdf_side_t;

endpackage
`default_nettype wire

// ----- hw/rtl/ncdf_div.sv -----
`default_nettype none
module ncdf_div import ncdf_pkg::*; #(
  parameter int QW = 31,
  parameter int DW = 32
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [DW-1:0] rem_in,
  input  wire logic [QW-1:0] low_in,
  input  wire logic [DW-1:0] divisor,
  output logic [QW-1:0]      quotient
);

  logic [DW-1:0] rem [QW];
  logic [QW-1:0] low [QW];
  logic [DW-1:0] dv  [QW];
  logic [QW-1:0] quo [QW];

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [DW-1:0] cur_rem;
    logic [QW-1:0] cur_low;
    logic [DW-1:0] cur_dv;
    logic [QW-1:0] cur_quo;
    logic [DW:0]   trial;
    logic          take;

    if (i == 0) begin : g_first
      assign cur_rem = rem_in;
      assign cur_low = low_in;
      assign cur_dv  = divisor;
      assign cur_quo = '0;
    end else begin : g_rest
      assign cur_rem = rem[i-1];
      assign cur_low = low[i-1];
      assign cur_dv  = dv[i-1];
      assign cur_quo = quo[i-1];
    end

    assign trial = {cur_rem, cur_low[QW-1]};
    assign take  = trial >= {1'b0, cur_dv};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= take ? DW'(trial - {1'b0, cur_dv}) : trial[DW-1:0];
        low[i] <= cur_low << 1;
        dv[i]  <= cur_dv;
        quo[i] <= {cur_quo[QW-2:0], take};
      end
    end
  end

  assign quotient = quo[QW-1];

endmodule
`default_nettype wire

// ----- hw/rtl/ncdf_exp.sv -----
`default_nettype none
module ncdf_exp import ncdf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [30:0] a,
  output logic [28:0]      phi
);

  logic [61:0] aa;
  ncdf_yr_t    yr0;

  // pipeline registers per exp term: multiply, reciprocal, correct
  logic [29:0] pa  [EXP_TERMS];
  ncdf_yr_t    ya  [EXP_TERMS];
  logic [29:0] q0b [EXP_TERMS];
  logic [29:0] pb  [EXP_TERMS];
  ncdf_yr_t    yb  [EXP_TERMS];
  logic [30:0] sc  [EXP_TERMS];
  ncdf_yr_t    yc  [EXP_TERMS];

  logic [30:0] e  [5];
  logic [4:0]  en_n [5];

  logic [59:0] phi_prod;

  assign aa = 62'(a) * 62'(a);

  always_ff @(posedge clk) begin
    if (en) begin
      yr0.n <= aa[61:57];
      yr0.r <= aa[56:27];
    end
  end

  for (genvar j = 0; j < EXP_TERMS; j++) begin : g_term
    logic [30:0] s_in;
    ncdf_yr_t    y_in;
    logic [60:0] rs;
    logic [62:0] pm;
    logic [33:0] rem;
    logic [29:0] q;

    if (j == 0) begin : g_first
      assign s_in = ONE_Q;
      assign y_in = yr0;
    end else begin : g_rest
      assign s_in = sc[j-1];
      assign y_in = yc[j-1];
    end

    assign rs  = 61'(y_in.r) * 61'(s_in);
    assign pm  = 63'(pa[j]) * 63'(EXP_RECIP[j]);
    assign rem = 34'(pb[j]) - 34'(q0b[j]) * 34'(EXP_DIV[j]);
    assign q   = (rem >= 34'(EXP_DIV[j])) ? 30'(q0b[j] + 30'd1) : q0b[j];

    always_ff @(posedge clk) begin
      if (en) begin
        pa[j]  <= rs[59:30];
        ya[j]  <= y_in;
        q0b[j] <= pm[61:32];
        pb[j]  <= pa[j];
        yb[j]  <= ya[j];
        sc[j]  <= ONE_Q - 31'(q);
        yc[j]  <= yb[j];
      end
    end
  end

  // scale by exp(-n), one set bit of n per stage
  for (genvar i = 0; i < 5; i++) begin : g_int
    logic [30:0] e_in;
    logic [4:0]  n_in;
    logic [59:0] prod;

    if (i == 0) begin : g_first
      assign e_in = sc[EXP_TERMS-1];
      assign n_in = yc[EXP_TERMS-1].n;
    end else begin : g_rest
      assign e_in = e[i-1];
      assign n_in = en_n[i-1];
    end

    assign prod = 60'(e_in) * 60'(K_EXPNEG[i]);

    always_ff @(posedge clk) begin
      if (en) begin
        e[i]    <= n_in[i] ? {1'b0, prod[59:30]} : e_in;
        en_n[i] <= n_in;
      end
    end
  end

  assign phi_prod = 60'(K_INV_SQRT_2PI) * 60'(e[4]);

  always_ff @(posedge clk) begin
    if (en) begin
      phi <= phi_prod[58:30];
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/ncdf_poly.sv -----
`default_nettype none
module ncdf_poly import ncdf_pkg::*; (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [30:0]        a,
  output logic signed [33:0]      acc
);

  logic [58:0] b0a;
  logic [31:0] den;
  logic [30:0] t;

  logic signed [33:0] hacc [5];
  logic [30:0]        ht   [5];

  assign b0a = 59'(K_B0) * 59'(a);

  always_ff @(posedge clk) begin
    if (en) begin
      den <= 32'(ONE_Q) + {1'b0, b0a[58:28]};
    end
  end

  // t = 2^60 / den
  ncdf_div #(.QW(DIV_STAGES), .DW(32)) u_recip (
    .clk      (clk),
    .en       (en),
    .rem_in   (32'h2000_0000),
    .low_in   ('0),
    .divisor  (den),
    .quotient (t)
  );

  for (genvar h = 0; h < 5; h++) begin : g_horner
    logic signed [33:0] a_in;
    logic [30:0]        t_in;
    logic               neg;
    logic [32:0]        mag;
    logic [63:0]        prod;
    logic signed [33:0] p;

    if (h == 0) begin : g_first
      assign a_in = K_B5;
      assign t_in = t;
    end else begin : g_rest
      assign a_in = hacc[h-1];
      assign t_in = ht[h-1];
    end

    assign neg  = a_in[33];
    assign mag  = neg ? 33'(-a_in) : a_in[32:0];
    assign prod = 64'(mag) * 64'(t_in);
    assign p    = neg ? -$signed({1'b0, prod[62:30]}) : $signed({1'b0, prod[62:30]});

    always_ff @(posedge clk) begin
      if (en) begin
        hacc[h] <= p + HORNER_ADD[h];
        ht[h]   <= t_in;
      end
    end
  end

  assign acc = hacc[4];

endmodule
`default_nettype wire

// ----- hw/rtl/normal_cdf_approximation.sv -----
// throughput: one beat per cycle; the pipeline freezes only while a result is
//   held on the output and stalled
// reset: rst clears all valid bits, mean to 0 and std_dev to 1.0
`default_nettype none
module normal_cdf_approximation import ncdf_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] sample,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [15:0]             probability
);

  logic [31:0] mean;
  logic [31:0] std_dev;
  logic        en;

  logic        v1;
  logic [32:0] d1;
  logic [31:0] sig1;

  logic        neg_next;
  logic [32:0] ad_next;
  logic        v2;
  logic        neg2;
  logic        far2;
  logic [32:0] ad2;
  logic [31:0] sig2;

  logic [30:0] a;
  logic [28:0] phi;
  logic signed [33:0] acc_raw;
  logic signed [33:0] acc_dly [ALIGN_LAT];
  ncdf_side_t  side [SIDE_LAT];

  logic [61:0] q_prod;
  logic        f1_v;
  logic        f1_neg;
  logic        f1_far;
  logic [31:0] q1;
  logic        out_neg;

  logic [32:0] p30;
  logic [33:0] p_sum;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      mean    <= '0;
      std_dev <= 32'd65536;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MEAN:    mean <= cfg_data;
        REG_STD_DEV: std_dev <= cfg_data;
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  assign neg_next = d1[32];
  assign ad_next  = neg_next ? 33'(33'd0 - d1) : d1;

  always_ff @(posedge clk) begin
    if (en) begin
      d1   <= {sample[31], sample} - {mean[31], mean};
      sig1 <= (std_dev == '0) ? 32'd1 : std_dev;
      ad2  <= ad_next;
      neg2 <= neg_next;
      far2 <= {2'b00, ad_next} >= {sig1, 3'b000};
      sig2 <= sig1;
    end
  end

  // a = |d| * 2^28 / sigma
  ncdf_div #(.QW(DIV_STAGES), .DW(32)) u_zdiv (
    .clk      (clk),
    .en       (en),
    .rem_in   ({2'b00, ad2[32:3]}),
    .low_in   ({ad2[2:0], 28'd0}),
    .divisor  (sig2),
    .quotient (a)
  );

  ncdf_exp u_exp (
    .clk (clk),
    .en  (en),
    .a   (a),
    .phi (phi)
  );

  ncdf_poly u_poly (
    .clk (clk),
    .en  (en),
    .a   (a),
    .acc (acc_raw)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SIDE_LAT; i++) begin
        side[i] <= '0;
      end
    end else if (en) begin
      side[0] <= '{v: v2, neg: neg2, far: far2};
      for (int i = 1; i < SIDE_LAT; i++) begin
        side[i] <= side[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_dly[0] <= acc_raw;
      for (int i = 1; i < ALIGN_LAT; i++) begin
        acc_dly[i] <= acc_dly[i-1];
      end
    end
  end

  assign q_prod = 62'(phi) * 62'(acc_dly[ALIGN_LAT-1][32:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
    end else if (en) begin
      f1_v <= side[SIDE_LAT-1].v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_neg <= side[SIDE_LAT-1].neg;
      f1_far <= side[SIDE_LAT-1].far;
      if (!side[SIDE_LAT-1].far && !acc_dly[ALIGN_LAT-1][33]
          && acc_dly[ALIGN_LAT-1] != '0) begin
        q1 <= q_prod[61:30];
      end else begin
        q1 <= '0;
      end
    end
  end

  always_comb begin
    if (f1_neg) begin
      p30 = {1'b0, q1};
    end else if (q1 > 32'(ONE_Q)) begin
      p30 = '0;
    end else begin
      p30 = 33'(ONE_Q) - {1'b0, q1};
    end
    p_sum = {1'b0, p30} + 34'h2000;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= f1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_neg     <= f1_neg;
      probability <= (p_sum[33:30] != '0) ? 16'hFFFF : p_sum[29:14];
    end
  end

`include "assert_macros.svh"

  `ASSERT_AFTER_RESET(a_reset_empty, !out_valid, "output valid right after reset")
  `ASSERT_NEXT(a_far_upper, en && f1_v && f1_far && !f1_neg, probability == 16'hFFFF, "far tail not saturated")
  `ASSERT_NOW(a_lower_half, !(out_valid && out_neg) || probability <= 16'd32800, "lower branch above one half")

endmodule
`default_nettype wire

// ----- tb/sv/ncdf_checker.sv -----
`default_nettype none
module ncdf_checker import ncdf_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic signed [31:0] sample,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic [15:0]        probability,
  output int                      fail_count,
  output int                      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] ONE = 64'd1 << WF;

  logic [31:0] cur_mean;
  logic [31:0] cur_sigma;
  logic [15:0] expected_prob [$];

  function automatic logic signed [63:0] trunc_mul(logic signed [63:0] a, logic [63:0] t);
    logic [63:0] m;
    logic [63:0] p;
    m = a < 0 ? -a : a;
    p = (m * t) >> WF;
    return a < 0 ? -$signed(p) : $signed(p);
  endfunction

  function automatic logic [15:0] cdf_of(logic signed [31:0] x);
    logic signed [63:0] d;
    logic signed [63:0] acc;
    logic [63:0] ad, sig, a, den, t, y, n, r, e, s, phi, q, p30, p16;
    logic signed [63:0] addend [5];
    addend = '{K_B4, K_B3, K_B2, K_B1, 0};
    sig = cur_sigma == 0 ? 64'd1 : {32'd0, cur_sigma};
    d = 64'(x) - 64'($signed(cur_mean));
    ad = d < 0 ? -d : d;
    q = 0;
    if (ad < 8 * sig) begin
      a = (ad << 28) / sig;
      den = ONE + ((64'(K_B0) * a) >> 28);
      t = (64'd1 << 60) / den;
      y = (a * a) >> 1;
      n = (y >> 56) & 31;
      r = (y >> 26) & (ONE - 1);
      s = ONE;
      for (int k = 12; k >= 1; k--) s = ONE - ((r * s) >> WF) / k;
      e = s;
      for (int i = 0; i < 5; i++)
        if (n[i]) e = (e * 64'(K_EXPNEG[i])) >> WF;
      phi = (64'(K_INV_SQRT_2PI) * e) >> WF;
      acc = K_B5;
      for (int i = 0; i < 5; i++) acc = trunc_mul(acc, t) + addend[i];
      if (acc > 0) q = (phi * acc) >> WF;
    end
    if (d < 0) p30 = q;
    else p30 = q > ONE ? 64'd0 : ONE - q;
    p16 = (p30 + (64'd1 << (WF - 17))) >> (WF - 16);
    if (p16 > 65535) p16 = 65535;
    return p16[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mean <= 0;
      cur_sigma <= 32'd65536;
      fail_count <= 0;
      expected_prob.delete();
    end else begin
      if (cfg_write && cfg_index == REG_MEAN) cur_mean <= cfg_data;
      if (cfg_write && cfg_index == REG_STD_DEV) cur_sigma <= cfg_data;
      if (in_valid && !in_stall) expected_prob.push_back(cdf_of(sample));
      if (out_valid && !out_stall) begin
        if (expected_prob.size() == 0) begin
          $display("%0t: unexpected beat, probability %0d", $time, probability);
          fail_count <= fail_count + 1;
        end else begin
          if (probability !== expected_prob[0]) begin
            $display("%0t: probability expected %0d actual %0d", $time,
                     expected_prob[0], probability);
            fail_count <= fail_count + 1;
          end
          void'(expected_prob.pop_front());
        end
      end
    end
  end

  assign pending = expected_prob.size();
endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
`default_nettype none
module testbench import ncdf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;

  logic clk, rst, cfg_write, in_valid, out_stall;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;
  logic signed [31:0] sample;
  logic in_stall, out_valid;
  logic [15:0] probability;
  int fail_count, pending;
  bit quiet, hold_out;

  normal_cdf_approximation dut (.*);
  ncdf_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("normal_cdf_approximation test failed");
    $finish;
  end

  initial begin
    out_stall = 0;
    @(posedge clk);
    forever begin
      if (hold_out) begin
        out_stall <= 1;
        repeat (200) @(posedge clk);
        out_stall <= 0;
        hold_out = 0;
      end else if (!quiet && $urandom_range(9) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(5, 1)) @(posedge clk);
        out_stall <= 0;
      end
      @(posedge clk);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 0;
    @(posedge clk);
  endtask

  task automatic send_sample(logic [31:0] x);
    if (!quiet && $urandom_range(7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(5, 1)) @(posedge clk);
    end
    in_valid <= 1;
    sample <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (90) @(posedge clk);
  endtask

  function automatic logic [31:0] near_mean(logic [31:0] m, logic [31:0] sd);
    logic [63:0] span;
    span = 64'(sd) * 9;
    if (span > 64'h7fff_ffff) span = 64'h7fff_ffff;
    return m + 32'($signed(64'($urandom_range(32'(span))) * 2 - span));
  endfunction

  initial begin
    logic [31:0] mean_v, sd_v;
    rst = 1;
    cfg_write = 0; cfg_index = 0; cfg_data = 0;
    in_valid = 0; sample = 0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_sample(0);
    send_sample(32'h7fff_ffff);
    send_sample(32'h8000_0000);
    send_sample(32'h0001_0000);
    send_sample(32'hffff_0000);
    send_sample(32'h0008_0000);
    send_sample(32'hfff8_0000);
    send_sample(32'h0007_ffff);
    send_sample(32'hfff8_0001);
    send_sample(32'h0000_0001);
    send_sample(32'hffff_ffff);
    drain();
    write_reg(REG_STD_DEV, 0);
    write_reg(REG_MEAN, 32'h8000_0000);
    write_reg(REG_SPARE_A, 32'h1234_5678);
    write_reg(REG_SPARE_B, 32'h0);
    send_sample(32'h8000_0000);
    send_sample(32'h8000_0001);
    send_sample(32'h8000_0008);
    send_sample(32'h7fff_ffff);
    drain();
    write_reg(REG_STD_DEV, 32'hffff_ffff);
    write_reg(REG_MEAN, 32'h7fff_ffff);
    send_sample(32'h8000_0000);
    send_sample(32'h7fff_ffff);
    send_sample(0);
    drain();
    for (int phase = 0; phase < 13; phase++) begin
      case ($urandom_range(3))
        0: sd_v = $urandom_range(255, 0);
        1: sd_v = $urandom_range(32'h0010_0000, 32'h0000_1000);
        2: sd_v = $urandom;
        default: sd_v = 32'h0001_0000;
      endcase
      mean_v = $urandom_range(1) ? $urandom : $urandom_range(32'h0004_0000);
      drain();
      write_reg(REG_STD_DEV, sd_v);
      write_reg(REG_MEAN, mean_v);
      if (phase == 0) hold_out = 1;
      if (phase == 12) quiet = 1;
      for (int i = 0; i < 100; i++)
        send_sample($urandom_range(4) == 0 ? $urandom : near_mean(mean_v, sd_v));
    end
    drain();
    if (fail_count == 0) begin
      $display("normal_cdf_approximation test passed");
    end else begin
      $display("normal_cdf_approximation test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
